[hw/rtl/imsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_pkg: shared types and constants of the spin update block
// lattice geometry, widths and the command bundle for the lattice store
// ----------------------------------------------------------------------------
package imsu_pkg;

   // lattice side, one row of the store holds one lattice row
   localparam int SIDE   = 16;
   localparam int IDX_W  = $clog2(SIDE);
   localparam int SITES  = SIDE * SIDE;

   // running totals
   localparam int SPIN_W = 10;
   localparam int BOND_W = 11;
   localparam int MAG_W  = 9;

   localparam logic signed [SPIN_W-1:0] SPIN_ALL_UP = SPIN_W'(SITES);
   localparam logic signed [SPIN_W-1:0] SPIN_ALL_DN = -SPIN_W'(SITES);
   localparam logic signed [BOND_W-1:0] BOND_FILL   = BOND_W'(2 * SITES);

   // command codes of the request channel
   localparam logic CMD_FLIP = 1'b0;
   localparam logic CMD_FILL = 1'b1;

   // register indexes of the csr channel
   localparam logic [1:0] REG_THRESH_FOUR  = 2'd0;
   localparam logic [1:0] REG_THRESH_EIGHT = 2'd1;
   localparam logic [1:0] REG_INIT_DOWN    = 2'd2;

   // requests toward the lattice store
   typedef struct packed {
      logic             fill;       // every site takes fill_down
      logic             fill_down;
      logic             wr_en;
      logic [IDX_W-1:0] wr_row;
      logic [SIDE-1:0]  wr_data;
      logic             rd_en_a;
      logic [IDX_W-1:0] rd_row_a;
      logic             rd_en_b;
      logic [IDX_W-1:0] rd_row_b;
   } lat_cmd_type;

endpackage

[hw/rtl/imsu_lattice.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imsu_lattice: row-organized spin store
// one write port, two registered read ports; per-row valid bits stand in
// for a lattice-wide fill; reads see the fill from the next cycle
// ----------------------------------------------------------------------------
module imsu_lattice (
   input  logic                        clock,
   input  logic                        reset,
   input  imsu_pkg::lat_cmd_type       cmd,
   output logic [imsu_pkg::SIDE-1:0]   rd_data_a,
   output logic [imsu_pkg::SIDE-1:0]   rd_data_b
);
   import imsu_pkg::*;

   logic [SIDE-1:0] lat_mem [SIDE];

   logic [SIDE-1:0] row_valid_ff;
   logic [SIDE-1:0] row_valid_in;
   logic            fill_down_ff;
   logic            fill_down_in;
   logic [SIDE-1:0] rd_data_a_ff;
   logic [SIDE-1:0] rd_data_b_ff;

   always_comb begin
      row_valid_in = row_valid_ff;
      fill_down_in = fill_down_ff;
      if (cmd.fill) begin
         row_valid_in = '0;
         fill_down_in = cmd.fill_down;
      end else if (cmd.wr_en) begin
         row_valid_in[cmd.wr_row] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      row_valid_ff <= row_valid_in;
      fill_down_ff <= fill_down_in;
      if (reset) begin
         row_valid_ff <= '0;
         fill_down_ff <= 1'b0;
      end
   end

   // storage array and registered reads; rows never written read as fill
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         lat_mem[cmd.wr_row] <= cmd.wr_data;
      end
      if (cmd.rd_en_a) begin
         rd_data_a_ff <= row_valid_ff[cmd.rd_row_a] ? lat_mem[cmd.rd_row_a]
                                                    : {SIDE{fill_down_ff}};
      end
      if (cmd.rd_en_b) begin
         rd_data_b_ff <= row_valid_ff[cmd.rd_row_b] ? lat_mem[cmd.rd_row_b]
                                                    : {SIDE{fill_down_ff}};
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

[hw/rtl/ising_metropolis_spin_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update: metropolis flip on a periodic spin lattice
// keeps a 16 x 16 lattice of one-bit spins with running magnetization and
// bond sum, and tries one flip or a full fill per request
// ----------------------------------------------------------------------------
// usage
//   req_ channel: one transfer per item (command, site, random word).
//   command flip reads the site row and the row below together, the row
//   above after them, then decides and writes the site row back.
//   command fill reloads the whole lattice via row valid bits.
//   rsp_ channel: one transfer per item, flipped flag, |magnetization| and
//   bond sum after the item; the result register shows it in the cycle after
//   the decision.
//   the lattice store has two read ports and the site needs three rows, so a
//   flip reads in ST_IDLE and ST_READ2; new requests wait until it is done.
//   req_ready is high in idle, also while a result still waits in the
//   output register; the next decision waits if it is full and rsp_ready low.
//   csr_ channel: index 0 and 1 are the two Q0.32 thresholds, index 2 the
//   fill orientation; always ready, other indexes are ignored.
//   reset: lattice all up, magnetization 256, bond sum 512, thresholds 0.
// ----------------------------------------------------------------------------
module ising_metropolis_spin_update (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_command,
   input  logic [3:0]                        req_site_x,
   input  logic [3:0]                        req_site_y,
   input  logic [31:0]                       req_random_word,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_flipped,
   output logic [imsu_pkg::MAG_W-1:0]        rsp_abs_magnetization,
   output logic signed [imsu_pkg::BOND_W-1:0] rsp_bond_sum,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [31:0]                       csr_wdata
);
   import imsu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ2,
      ST_EVAL,
      ST_FILL
   } state_type;

   state_type                 state_ff, state_in;

   // configuration
   logic [31:0]               thresh_four_ff,  thresh_four_in;
   logic [31:0]               thresh_eight_ff, thresh_eight_in;
   logic                      init_down_ff,    init_down_in;

   // running totals
   logic signed [SPIN_W-1:0]  total_spin_ff, total_spin_in;
   logic signed [BOND_W-1:0]  bond_total_ff, bond_total_in;

   // captured request
   logic [IDX_W-1:0]          x_ff, x_in;
   logic [IDX_W-1:0]          y_ff, y_in;
   logic [31:0]               rand_ff, rand_in;
   logic                      n_dn_ff, n_dn_in;

   // result register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_flipped_ff, rsp_flipped_in;
   logic [MAG_W-1:0]          rsp_mag_ff, rsp_mag_in;
   logic signed [BOND_W-1:0]  rsp_bond_ff, rsp_bond_in;

   lat_cmd_type               lat_cmd;
   logic [SIDE-1:0]           rd_data_a;
   logic [SIDE-1:0]           rd_data_b;

   logic [IDX_W-1:0]          req_x, req_y;
   logic [IDX_W-1:0]          xp, xm, yp, ym;
   logic                      spin_b, n_up, n_l, n_r;
   logic [2:0]                n_diff;
   logic                      accept;
   logic                      slot_free;
   logic signed [SPIN_W-1:0]  spin_next;
   logic signed [SPIN_W-1:0]  fill_spin;
   logic                      req_xfer;

   imsu_lattice u_lattice (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lat_cmd),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // site indexes wrap modulo the side
   assign req_x = IDX_W'(req_site_x);
   assign req_y = IDX_W'(req_site_y);
   assign xp = (x_ff == IDX_W'(SIDE - 1)) ? '0 : x_ff + 1'b1;
   assign xm = (x_ff == '0) ? IDX_W'(SIDE - 1) : x_ff - 1'b1;
   assign yp = (y_ff == IDX_W'(SIDE - 1)) ? '0 : y_ff + 1'b1;
   assign ym = (y_ff == '0) ? IDX_W'(SIDE - 1) : y_ff - 1'b1;

   // in eval: port a holds the site row, port b the row above
   assign spin_b = rd_data_a[y_ff];
   assign n_l    = rd_data_a[ym];
   assign n_r    = rd_data_a[yp];
   assign n_up   = rd_data_b[y_ff];

   // neighbours of opposite spin; action change is (2 - n_diff) * 4J/T
   assign n_diff = 3'(n_up ^ spin_b) + 3'(n_dn_ff ^ spin_b)
                 + 3'(n_l ^ spin_b) + 3'(n_r ^ spin_b);

   always_comb begin
      if (n_diff >= 3'd2) begin
         accept = 1'b1;
      end else if (n_diff == 3'd1) begin
         accept = rand_ff < thresh_four_ff;
      end else begin
         accept = rand_ff < thresh_eight_ff;
      end
   end

   // up spin (bit 0) leaving lowers the total by two
   assign spin_next = spin_b ? total_spin_ff + SPIN_W'(2) : total_spin_ff - SPIN_W'(2);
   assign fill_spin = init_down_ff ? SPIN_ALL_DN : SPIN_ALL_UP;

   always_comb begin
      state_in        = state_ff;
      thresh_four_in  = thresh_four_ff;
      thresh_eight_in = thresh_eight_ff;
      init_down_in    = init_down_ff;
      total_spin_in   = total_spin_ff;
      bond_total_in   = bond_total_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      rand_in         = rand_ff;
      n_dn_in         = n_dn_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_flipped_in  = rsp_flipped_ff;
      rsp_mag_in      = rsp_mag_ff;
      rsp_bond_in     = rsp_bond_ff;
      lat_cmd         = '0;
      lat_cmd.wr_row  = x_ff;
      lat_cmd.wr_data = rd_data_a;
      lat_cmd.wr_data[y_ff] = ~spin_b;
      lat_cmd.fill_down = init_down_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_THRESH_FOUR:  thresh_four_in  = csr_wdata;
            REG_THRESH_EIGHT: thresh_eight_in = csr_wdata;
            REG_INIT_DOWN:    init_down_in    = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               x_in    = req_x;
               y_in    = req_y;
               rand_in = req_random_word;
               if (req_command == CMD_FILL) begin
                  state_in = ST_FILL;
               end else begin
                  // site row on port a, row below on port b
                  lat_cmd.rd_en_a  = 1'b1;
                  lat_cmd.rd_row_a = req_x;
                  lat_cmd.rd_en_b  = 1'b1;
                  lat_cmd.rd_row_b = (req_x == IDX_W'(SIDE - 1)) ? '0 : req_x + 1'b1;
                  state_in = ST_READ2;
               end
            end
         end
         ST_READ2: begin
            n_dn_in          = rd_data_b[y_ff];
            lat_cmd.rd_en_b  = 1'b1;
            lat_cmd.rd_row_b = xm;
            state_in         = ST_EVAL;
         end
         ST_EVAL: begin
            // decision waits until the result register can take it
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_flipped_in = accept;
               if (accept) begin
                  lat_cmd.wr_en = 1'b1;
                  total_spin_in = spin_next;
                  bond_total_in = bond_total_ff - BOND_W'(8) + BOND_W'({n_diff, 2'b00});
               end
               rsp_bond_in = bond_total_in;
               rsp_mag_in  = (total_spin_in < 0) ? MAG_W'(-total_spin_in)
                                                 : MAG_W'(total_spin_in);
               state_in = ST_IDLE;
            end
         end
         ST_FILL: begin
            if (slot_free) begin
               lat_cmd.fill   = 1'b1;
               total_spin_in  = fill_spin;
               bond_total_in  = BOND_FILL;
               rsp_valid_in   = 1'b1;
               rsp_flipped_in = 1'b0;
               rsp_mag_in     = MAG_W'(SITES);
               rsp_bond_in    = BOND_FILL;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      state_ff        <= state_in;
      thresh_four_ff  <= thresh_four_in;
      thresh_eight_ff <= thresh_eight_in;
      init_down_ff    <= init_down_in;
      total_spin_ff   <= total_spin_in;
      bond_total_ff   <= bond_total_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      rand_ff         <= rand_in;
      n_dn_ff         <= n_dn_in;
      rsp_valid_ff    <= rsp_valid_in;
      rsp_flipped_ff  <= rsp_flipped_in;
      rsp_mag_ff      <= rsp_mag_in;
      rsp_bond_ff     <= rsp_bond_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         thresh_four_ff  <= '0;
         thresh_eight_ff <= '0;
         init_down_ff    <= 1'b0;
         total_spin_ff   <= SPIN_ALL_UP;
         bond_total_ff   <= BOND_FILL;
         rsp_valid_ff    <= 1'b0;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_flipped           = rsp_flipped_ff;
   assign rsp_abs_magnetization = rsp_mag_ff;
   assign rsp_bond_sum          = rsp_bond_ff;

`ifndef ASSERT_OFF
   // totals move in steps of two and four from even starting points
   a_totals_aligned: assert property (@(posedge clock) disable iff (reset)
      !total_spin_ff[0] && (bond_total_ff[1:0] == 2'b00))
      else $error("running totals lost their alignment");

   // a result only appears out of a decision or a fill
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EVAL || $past(state_ff) == ST_FILL))
      else $error("result raised outside eval or fill");

   // fill restores the fully aligned bond sum
   a_fill_bond: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && slot_free) |=> (bond_total_ff == BOND_FILL))
      else $error("fill did not restore bond sum");

   // magnetization never exceeds the site count
   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_mag_ff <= MAG_W'(SITES)))
      else $error("magnetization out of range");
`endif

endmodule
